[hdl/smpq_pkg.sv]
// shared constants and types for the stable minimum priority queue
package smpq_pkg;

	localparam int CAPACITY_DEF      = 16;
	localparam int PRIORITY_BITS_DEF = 8;
	localparam int TAG_BITS_DEF      = 16;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} op_t;

	typedef struct packed {
		logic insert;
		logic remove;
	} cell_ctrl_t;

endpackage

[hdl/smpq_cell.sv]
// one slot of the sorted shift chain: holds an entry, shifts right on insert, left on remove
module smpq_cell #(
	parameter int PRIORITY_BITS = smpq_pkg::PRIORITY_BITS_DEF,
	parameter int TAG_BITS      = smpq_pkg::TAG_BITS_DEF
) (
	input  logic                     clk,
	input  smpq_pkg::cell_ctrl_t     ctrl,
	input  logic                     occupied,
	input  logic [PRIORITY_BITS-1:0] new_priority,
	input  logic [TAG_BITS-1:0]      new_tag,
	input  logic                     left_keep,
	input  logic [PRIORITY_BITS-1:0] left_priority,
	input  logic [TAG_BITS-1:0]      left_tag,
	input  logic [PRIORITY_BITS-1:0] right_priority,
	input  logic [TAG_BITS-1:0]      right_tag,
	output logic                     keep,
	output logic [PRIORITY_BITS-1:0] slot_priority,
	output logic [TAG_BITS-1:0]      slot_tag
);

	logic [PRIORITY_BITS-1:0] priority_q;
	logic [TAG_BITS-1:0]      tag_q;

	// entry stays in place when it is not later than the new one
	assign keep          = occupied && (priority_q <= new_priority);
	assign slot_priority = priority_q;
	assign slot_tag      = tag_q;

	always_ff @(posedge clk) begin
		if (ctrl.insert && !keep) begin
			if (left_keep) begin
				priority_q <= new_priority;
				tag_q      <= new_tag;
			end else begin
				priority_q <= left_priority;
				tag_q      <= left_tag;
			end
		end else if (ctrl.remove) begin
			priority_q <= right_priority;
			tag_q      <= right_tag;
		end
	end

endmodule

[hdl/stable_min_priority_queue_unit.sv]
// stable minimum priority queue built as a sorted chain of shifting slots
//
//  channel   ports                                         handshake
//  request   operation, new_priority, new_tag              start && !busy
//  result    out_valid, out_priority, out_tag, rejected,   done, one cycle wide
//            is_empty, fill_count
//
// one request per cycle; busy stays low
// the result appears with done in the cycle after the request is taken
// every slot compares against the new priority and shifts in the same cycle
// reset empties the queue; slot contents are left as they are
// results cannot be stalled by the receiver
module stable_min_priority_queue_unit #(
	parameter int CAPACITY      = smpq_pkg::CAPACITY_DEF,
	parameter int PRIORITY_BITS = smpq_pkg::PRIORITY_BITS_DEF,
	parameter int TAG_BITS      = smpq_pkg::TAG_BITS_DEF,
	localparam int CW           = $clog2(CAPACITY + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic                     operation,
	input  logic [PRIORITY_BITS-1:0] new_priority,
	input  logic [TAG_BITS-1:0]      new_tag,
	output logic                     done,
	output logic                     out_valid,
	output logic [PRIORITY_BITS-1:0] out_priority,
	output logic [TAG_BITS-1:0]      out_tag,
	output logic                     rejected,
	output logic                     is_empty,
	output logic [CW-1:0]            fill_count
);

	logic [CW-1:0]            count_q;
	logic                     done_q;
	logic                     valid_q;
	logic                     rejected_q;
	logic [PRIORITY_BITS-1:0] out_priority_q;
	logic [TAG_BITS-1:0]      out_tag_q;

	logic                     is_insert;
	logic                     is_remove;
	logic                     full;
	logic                     empty;
	smpq_pkg::cell_ctrl_t     ctrl;

	logic                     keep      [CAPACITY];
	logic [PRIORITY_BITS-1:0] cell_prio [CAPACITY];
	logic [TAG_BITS-1:0]      cell_tag  [CAPACITY];

	assign busy      = 1'b0;
	assign is_insert = start && (operation == smpq_pkg::OP_INSERT);
	assign is_remove = start && (operation == smpq_pkg::OP_REMOVE);
	assign full      = (count_q == CW'(CAPACITY));
	assign empty     = (count_q == '0);
	assign ctrl.insert = is_insert && !full;
	assign ctrl.remove = is_remove && !empty;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                     left_keep;
		logic [PRIORITY_BITS-1:0] left_priority;
		logic [TAG_BITS-1:0]      left_tag;
		logic [PRIORITY_BITS-1:0] right_priority;
		logic [TAG_BITS-1:0]      right_tag;

		if (i == 0) begin : g_head
			assign left_keep     = 1'b1;
			assign left_priority = new_priority;
			assign left_tag      = new_tag;
		end else begin : g_mid
			assign left_keep     = keep[i-1];
			assign left_priority = cell_prio[i-1];
			assign left_tag      = cell_tag[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_priority = cell_prio[i];
			assign right_tag      = cell_tag[i];
		end else begin : g_body
			assign right_priority = cell_prio[i+1];
			assign right_tag      = cell_tag[i+1];
		end

		smpq_cell #(
			.PRIORITY_BITS(PRIORITY_BITS),
			.TAG_BITS     (TAG_BITS)
		) u_cell (
			.clk           (clk),
			.ctrl          (ctrl),
			.occupied      (CW'(i) < count_q),
			.new_priority  (new_priority),
			.new_tag       (new_tag),
			.left_keep     (left_keep),
			.left_priority (left_priority),
			.left_tag      (left_tag),
			.right_priority(right_priority),
			.right_tag     (right_tag),
			.keep          (keep[i]),
			.slot_priority (cell_prio[i]),
			.slot_tag      (cell_tag[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			done_q     <= 1'b0;
			valid_q    <= 1'b0;
			rejected_q <= 1'b0;
		end else begin
			done_q     <= start;
			valid_q    <= ctrl.remove;
			rejected_q <= is_insert && full;
			if (ctrl.insert) begin
				count_q <= count_q + CW'(1);
			end else if (ctrl.remove) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.remove) begin
			out_priority_q <= cell_prio[0];
			out_tag_q      <= cell_tag[0];
		end else begin
			out_priority_q <= '0;
			out_tag_q      <= '0;
		end
	end

	assign done         = done_q;
	assign out_valid    = valid_q;
	assign out_priority = out_priority_q;
	assign out_tag      = out_tag_q;
	assign rejected     = rejected_q;
	assign is_empty     = (count_q == '0);
	assign fill_count   = count_q;

endmodule

[bench/tb.sv]
// testbench for the stable minimum priority queue: random and directed requests checked against a sorted-store predictor
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import smpq_pkg::*;

	localparam int CAP          = CAPACITY_DEF;
	localparam int PB           = PRIORITY_BITS_DEF;
	localparam int TB_BITS      = TAG_BITS_DEF;
	localparam int CW           = $clog2(CAP + 1);
	localparam int CLK_PERIOD   = 8;
	localparam int RANDOM_ITEMS = 850;
	localparam int STALL_LIMIT  = 1000;
	localparam int TAIL_CYCLES  = 4;

	typedef struct {
		op_t               op;
		logic [PB-1:0]     prio;
		logic [TB_BITS-1:0] tag;
		int unsigned       wait_cycles;
		bit                drain;
	} queue_req_t;

	typedef struct {
		logic               valid;
		logic [PB-1:0]      prio;
		logic [TB_BITS-1:0] tag;
		logic               rejected;
		logic               empty;
		logic [CW-1:0]      count;
	} queue_resp_t;

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               start        = 1'b0;
	logic               operation    = OP_INSERT;
	logic [PB-1:0]      new_priority = '0;
	logic [TB_BITS-1:0] new_tag      = '0;
	logic               busy;
	logic               done;
	logic               out_valid;
	logic [PB-1:0]      out_priority;
	logic [TB_BITS-1:0] out_tag;
	logic               rejected;
	logic               is_empty;
	logic [CW-1:0]      fill_count;

	queue_req_t   pending_requests[$];
	queue_resp_t  expected_responses[$];
	queue_req_t   active_req;
	logic [PB-1:0]      model_prio[CAP];
	logic [TB_BITS-1:0] model_tag[CAP];
	int           model_count = 0;
	int           mismatches  = 0;
	int           stall_cycles = 0;

	stable_min_priority_queue_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.operation    (operation),
		.new_priority (new_priority),
		.new_tag      (new_tag),
		.done         (done),
		.out_valid    (out_valid),
		.out_priority (out_priority),
		.out_tag      (out_tag),
		.rejected     (rejected),
		.is_empty     (is_empty),
		.fill_count   (fill_count)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic queue_req_t make_req(input op_t op, input logic [PB-1:0] prio,
			input logic [TB_BITS-1:0] tag, input int unsigned wait_cycles, input bit drain);
		queue_req_t r;
		r.op          = op;
		r.prio        = prio;
		r.tag         = tag;
		r.wait_cycles = wait_cycles;
		r.drain       = drain;
		return r;
	endfunction

	function automatic void predict_queue_response(input queue_req_t r);
		queue_resp_t rsp;
		int pos;
		rsp = '{default: '0};
		if (r.op == OP_INSERT) begin
			if (model_count >= CAP) begin
				rsp.rejected = 1'b1;
			end else begin
				pos = 0;
				while (pos < model_count && model_prio[pos] <= r.prio)
					pos++;
				for (int i = model_count; i > pos; i--) begin
					model_prio[i] = model_prio[i-1];
					model_tag[i]  = model_tag[i-1];
				end
				model_prio[pos] = r.prio;
				model_tag[pos]  = r.tag;
				model_count++;
			end
		end else if (model_count != 0) begin
			rsp.valid = 1'b1;
			rsp.prio  = model_prio[0];
			rsp.tag   = model_tag[0];
			for (int i = 1; i < model_count; i++) begin
				model_prio[i-1] = model_prio[i];
				model_tag[i-1]  = model_tag[i];
			end
			model_count--;
		end
		rsp.empty = (model_count == 0);
		rsp.count = CW'(model_count);
		expected_responses.push_back(rsp);
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		logic launch;
		if (!arst_n) begin
			start        <= 1'b0;
			operation    <= OP_INSERT;
			new_priority <= '0;
			new_tag      <= '0;
		end else if (!(start && busy)) begin
			if (start)
				predict_queue_response(active_req);
			launch = 1'b0;
			if (pending_requests.size() != 0) begin
				if (pending_requests[0].wait_cycles != 0)
					pending_requests[0].wait_cycles = pending_requests[0].wait_cycles - 1;
				else if (!pending_requests[0].drain ||
						(expected_responses.size() == 0 && !done && !start))
					launch = 1'b1;
			end
			if (launch) begin
				active_req   = pending_requests.pop_front();
				operation    <= active_req.op;
				new_priority <= active_req.prio;
				new_tag      <= active_req.tag;
			end
			start <= launch;
		end
	end

	// result monitor
	always @(posedge clk) begin
		queue_resp_t want;
		if (arst_n && done) begin
			if (expected_responses.size() == 0) begin
				$error("result with no request outstanding");
				mismatches++;
			end else begin
				want = expected_responses.pop_front();
				check_field("out_valid", 32'(want.valid), 32'(out_valid));
				check_field("out_priority", 32'(want.prio), 32'(out_priority));
				check_field("out_tag", 32'(want.tag), 32'(out_tag));
				check_field("rejected", 32'(want.rejected), 32'(rejected));
				check_field("is_empty", 32'(want.empty), 32'(is_empty));
				check_field("fill_count", 32'(want.count), 32'(fill_count));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		op_t           op;
		logic [PB-1:0] prio;
		int            total;
		int            burst_len;
		int            insert_pct;
		int            prio_mode;
		bit            no_gaps;

		// remove from empty, extremes, ties kept in arrival order
		pending_requests.push_back(make_req(OP_REMOVE, 8'hff, 16'hffff, 0, 1'b0));
		pending_requests.push_back(make_req(OP_INSERT, 8'hff, 16'hffff, 0, 1'b0));
		pending_requests.push_back(make_req(OP_INSERT, 8'h00, 16'h0000, 1, 1'b0));
		pending_requests.push_back(make_req(OP_INSERT, 8'h80, 16'h1111, 0, 1'b0));
		pending_requests.push_back(make_req(OP_INSERT, 8'h80, 16'h2222, 0, 1'b0));
		pending_requests.push_back(make_req(OP_INSERT, 8'h80, 16'h3333, 2, 1'b0));
		pending_requests.push_back(make_req(OP_INSERT, 8'h00, 16'haaaa, 0, 1'b0));
		pending_requests.push_back(make_req(OP_INSERT, 8'hff, 16'h5555, 0, 1'b0));
		for (int k = 0; k < 8; k++)
			pending_requests.push_back(make_req(OP_REMOVE, 8'(k), 16'(k), 0, 1'b0));
		pending_requests.push_back(make_req(OP_REMOVE, 8'h00, 16'h0000, 0, 1'b0));

		total = 0;
		while (total < RANDOM_ITEMS) begin
			burst_len = $urandom_range(8, 48);
			case ($urandom_range(0, 2))
				0: insert_pct = 85;
				1: insert_pct = 25;
				default: insert_pct = 55;
			endcase
			prio_mode = $urandom_range(0, 2);
			no_gaps   = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < burst_len; k++) begin
				op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
				case (prio_mode)
					0: prio = 8'($urandom_range(0, 3)) | (($urandom_range(0, 1) != 0) ? 8'hfc : 8'h00);
					1: prio = 8'($urandom());
					default: prio = ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
				endcase
				pending_requests.push_back(make_req(op, prio, 16'($urandom()),
						no_gaps ? 0 : $urandom_range(0, 4),
						k == 0 && (total == 0 || $urandom_range(0, 3) == 0)));
				total++;
			end
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_requests.size() != 0 || start)
			@(posedge clk);
		while (expected_responses.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

[sim.f]
hdl/smpq_pkg.sv
hdl/smpq_cell.sv
hdl/stable_min_priority_queue_unit.sv
bench/tb.sv
